/* sv/assert_macros.svh */
// Assertion macros shared by the RTL modules of the row-subset remap core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define SRSR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("srsr assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define SRSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("srsr implication failed");

// Check that a condition implies a consequence in the next cycle.
`define SRSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("srsr next-cycle implication failed");

`endif

/* sv/srsr_pkg.sv */
// Package with constants, codes and control types of the row-subset remap core.
`default_nettype none

package srsr_pkg;

	// Key table geometry
	localparam int KEY_SLOTS = 256;
	localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CNT_W     = $clog2(KEY_SLOTS + 1);
	localparam int POS_EXT_W = (IDX_W > 8) ? IDX_W : 8;

	// Input item kinds
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_ENTRY = 2'd2;
	localparam logic [1:0] KIND_CLOSE = 2'd3;

	// Result kinds
	localparam logic RES_ENTRY   = 1'b0;
	localparam logic RES_POINTER = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic scan_start;
		logic scan;
		logic emit;
		logic emit_close;
	} srsr_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic keys_empty;
		logic hit;
		logic miss_done;
		logic out_free;
	} srsr_status_t;

endpackage

`default_nettype wire

/* sv/srsr_if.sv */
// Stream interfaces for input items and result items of the row-subset remap core.
`default_nettype none

interface srsr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface srsr_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  new_index;
	logic [31:0] column;
	logic        first_in_column;
	logic [31:0] pointer_value;

	modport source (output valid, output result_kind, output new_index, output column,
		output first_in_column, output pointer_value, input ready);
	modport sink (input valid, input result_kind, input new_index, input column,
		input first_in_column, input pointer_value, output ready);
endinterface

`default_nettype wire

/* sv/srsr_ctrl.sv */
// Controller state machine: accepts items, sequences key scans and result emission.
`default_nettype none
`include "assert_macros.svh"

module srsr_ctrl
	import srsr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [1:0]   in_kind,
	output logic              in_ready,
	input  wire srsr_status_t status,
	output srsr_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       close_q;
	logic       accept;

	// Take a transaction only while idle
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode commands
	always_comb begin
		cmd.clear      = accept && (in_kind == KIND_CLEAR);
		cmd.load       = accept && (in_kind == KIND_LOAD);
		cmd.scan_start = accept && (in_kind == KIND_ENTRY) && !status.keys_empty;
		cmd.scan       = (state_q == ST_SCAN);
		cmd.emit       = (state_q == ST_EMIT) && status.out_free;
		cmd.emit_close = close_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_ENTRY: if (!status.keys_empty) state_d = ST_SCAN;
						KIND_CLOSE: state_d = ST_EMIT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (status.hit) state_d = ST_EMIT;
				else if (status.miss_done) state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and the kind of result being produced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			close_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) close_q <= (in_kind == KIND_CLOSE);
		end
	end

	`SRSR_ASSERT_NXT(a_hit_emits, clk, arst_n, cmd.scan && status.hit, state_q == ST_EMIT)
	`SRSR_ASSERT_NXT(a_emit_waits, clk, arst_n, (state_q == ST_EMIT) && !status.out_free,
		state_q == ST_EMIT)
	`SRSR_ASSERT_NXT(a_start_scans, clk, arst_n, cmd.scan_start,
		(state_q == ST_SCAN) && !close_q)

endmodule

`default_nettype wire

/* sv/srsr_datapath.sv */
// Datapath: key memory, scan pipeline, running counters and result register.
`default_nettype none
`include "assert_macros.svh"

module srsr_datapath
	import srsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] in_value,
	input  wire srsr_cmd_t   cmd,
	output srsr_status_t     status,
	srsr_out_if.source       results
);

	logic [31:0]          key_mem [KEY_SLOTS];
	logic [CNT_W-1:0]     keys_loaded_q;
	logic [31:0]          kept_q;
	logic [31:0]          column_q;
	logic                 has_kept_q;
	logic [31:0]          value_q;
	logic [IDX_W-1:0]     scan_addr_q;
	logic                 issue_q;
	logic [31:0]          rd_data_s1;
	logic [IDX_W-1:0]     rd_pos_s1;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     pos_q;
	logic [POS_EXT_W-1:0] pos_ext;
	logic                 out_vld_q;
	logic                 res_kind_q;
	logic [7:0]           new_index_q;
	logic [31:0]          res_column_q;
	logic                 first_q;
	logic [31:0]          ptr_q;
	logic                 hit;

	// Compare the registered read against the searched row index
	assign hit     = rd_vld_s1 && (rd_data_s1 == value_q);
	assign pos_ext = POS_EXT_W'(pos_q);

	always_comb begin
		status.keys_empty = (keys_loaded_q == '0);
		status.hit        = hit;
		status.miss_done  = rd_vld_s1 && !hit && (rd_pos_s1 == '0);
		status.out_free   = !out_vld_q || results.ready;
	end

	// Write loaded keys and read one key per cycle during a scan
	always_ff @(posedge clk) begin
		if (cmd.load && (keys_loaded_q < CNT_W'(KEY_SLOTS))) begin
			key_mem[keys_loaded_q[IDX_W-1:0]] <= in_value;
		end
		rd_data_s1 <= key_mem[scan_addr_q];
		rd_pos_s1  <= scan_addr_q;
	end

	// Advance the scan address from the highest loaded position downward
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			value_q     <= in_value;
			scan_addr_q <= IDX_W'(keys_loaded_q - CNT_W'(1));
		end else if (cmd.scan && issue_q) begin
			scan_addr_q <= scan_addr_q - IDX_W'(1);
		end
		if (cmd.scan && hit) pos_q <= rd_pos_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.scan_start) issue_q <= 1'b1;
			else if (cmd.scan && issue_q && (scan_addr_q == '0)) issue_q <= 1'b0;
			else if (!cmd.scan) issue_q <= 1'b0;
			rd_vld_s1 <= cmd.scan && issue_q && !cmd.scan_start;
		end
	end

	// Update key count, kept count and column position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_loaded_q <= '0;
			kept_q        <= '0;
			column_q      <= '0;
			has_kept_q    <= 1'b0;
		end else if (cmd.clear) begin
			keys_loaded_q <= '0;
			kept_q        <= '0;
			column_q      <= '0;
			has_kept_q    <= 1'b0;
		end else begin
			if (cmd.load && (keys_loaded_q < CNT_W'(KEY_SLOTS))) begin
				keys_loaded_q <= keys_loaded_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				if (cmd.emit_close) begin
					column_q   <= column_q + 32'd1;
					has_kept_q <= 1'b0;
				end else begin
					if (kept_q != '1) kept_q <= kept_q + 32'd1;
					has_kept_q <= 1'b1;
				end
			end
		end
	end

	// Hold the result until the downstream side takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_column_q <= column_q;
			if (cmd.emit_close) begin
				res_kind_q  <= RES_POINTER;
				new_index_q <= 8'd0;
				first_q     <= 1'b0;
				ptr_q       <= kept_q;
			end else begin
				res_kind_q  <= RES_ENTRY;
				new_index_q <= pos_ext[7:0];
				first_q     <= !has_kept_q;
				ptr_q       <= 32'd0;
			end
		end
	end

	assign results.valid           = out_vld_q;
	assign results.result_kind     = res_kind_q;
	assign results.new_index       = new_index_q;
	assign results.column          = res_column_q;
	assign results.first_in_column = first_q;
	assign results.pointer_value   = ptr_q;

	`SRSR_ASSERT_NXT(a_emit_valid, clk, arst_n, cmd.emit, out_vld_q)
	`SRSR_ASSERT(a_count_bound, clk, arst_n, keys_loaded_q <= CNT_W'(KEY_SLOTS))
	`SRSR_ASSERT_IMP(a_read_loaded, clk, arst_n, rd_vld_s1,
		CNT_W'(rd_pos_s1) < keys_loaded_q)

endmodule

`default_nettype wire

/* sv/sparse_row_subset_remap_core.sv */
// Clear and load give no result; a close or a hit is registered as a result once the
// output is free. An entry scans the key memory from the highest loaded position
// downward, one read a cycle on its single read port; a miss frees the block once
// position 0 has been read. Asynchronous reset clears counters, column and control;
// the key memory is not cleared, and positions never loaded never give a valid read.
`default_nettype none

module sparse_row_subset_remap_core
	import srsr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	srsr_in_if.sink    items,
	srsr_out_if.source results
);

	srsr_cmd_t    cmd;
	srsr_status_t status;
	logic         ready;

	assign items.ready = ready;

	// Sequence transactions
	srsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_kind  (items.kind),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Store keys, scan and produce results
	srsr_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_value (items.value),
		.cmd      (cmd),
		.status   (status),
		.results  (results)
	);

endmodule

`default_nettype wire
